// ----- hdl/sir_grid_cell_update_defines.svh -----
// assertion macros shared by the sir grid cell update modules
// depends on nothing; the asserting modules must have i_clk and i_rst_n ports
`ifndef SIR_GRID_CELL_UPDATE_DEFINES_SVH
`define SIR_GRID_CELL_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define SGCU_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sgcu assertion failed");
// next-cycle implication
`define SGCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sgcu assertion failed");
`else
`define SGCU_ASSERT(label, ante, cons)
`define SGCU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/sgcu_pkg.sv -----
// shared types, codes and constants of the sir grid cell update block
// depends on nothing
package sgcu_pkg;

    // default values of the top level parameters
    localparam int GRID_SIDE_DEF = 512;
    localparam int PROB_BITS_DEF = 16;

    // fixed field widths
    localparam int COORD_W = 9;
    localparam int CODE_W  = 2;
    localparam int PROB_W  = 16;
    localparam int NBR_W   = 4;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // cell codes
    localparam logic [CODE_W-1:0] CODE_SUS = 2'd0;
    localparam logic [CODE_W-1:0] CODE_INF = 2'd1;
    localparam logic [CODE_W-1:0] CODE_REC = 2'd2;

    // register indexes and reset values
    localparam logic REG_INFECT  = 1'b0;
    localparam logic REG_RECOVER = 1'b1;
    localparam logic [PROB_W-1:0] RST_INFECT  = 16'd19661;
    localparam logic [PROB_W-1:0] RST_RECOVER = 16'd3277;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_SWAP   = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

    // moore neighbourhood walk
    localparam int NBR_NUM   = 8;
    localparam int NBR_IDX_W = 3;
    localparam logic [1:0] OFF_M1   = 2'd0;
    localparam logic [1:0] OFF_ZERO = 2'd1;
    localparam logic [1:0] OFF_P1   = 2'd2;
    localparam logic [1:0] NBR_DR [NBR_NUM] = '{OFF_M1, OFF_M1, OFF_M1, OFF_ZERO,
                                               OFF_ZERO, OFF_P1, OFF_P1, OFF_P1};
    localparam logic [1:0] NBR_DC [NBR_NUM] = '{OFF_M1, OFF_ZERO, OFF_P1, OFF_M1,
                                               OFF_P1, OFF_M1, OFF_ZERO, OFF_P1};

    // sequencer to bank memories
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_next;
        logic swap;
    } t_bank_ctl;

    // sequencer to top level
    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_seq_stat;

endpackage

// ----- hdl/sgcu_wrap.sv -----
// reduces a raw grid coordinate modulo the grid side, registered output
// depends on sgcu_pkg
module sgcu_wrap import sgcu_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic [COORD_W-1:0]           i_x,
    output logic [$clog2(GRID_SIDE)-1:0] o_y
);
    localparam int AW    = $clog2(GRID_SIDE);
    localparam int RSH   = 20;
    localparam int RCW   = RSH + 1;
    localparam int RECIP = (1 << RSH) / GRID_SIDE;
    localparam int PW    = COORD_W + RCW;
    localparam int WW    = COORD_W + AW + 1;

    logic [PW-1:0]      w_prod;
    logic [COORD_W-1:0] r_q;
    logic [COORD_W-1:0] r_x;
    logic [WW-1:0]      w_rem;
    logic [WW-1:0]      w_fix;
    logic [AW-1:0]      r_y;

    // quotient estimate by reciprocal, at most one short
    assign w_prod = PW'(i_x) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        r_q <= w_prod[RSH +: COORD_W];
        r_x <= i_x;
    end

    // remainder stays below twice the side, one correction step
    assign w_rem = WW'(r_x) - WW'(r_q) * WW'(GRID_SIDE);
    assign w_fix = (w_rem >= WW'(GRID_SIDE)) ? (w_rem - WW'(GRID_SIDE)) : w_rem;

    always_ff @(posedge i_clk) begin
        r_y <= w_fix[AW-1:0];
    end

    assign o_y = r_y;

endmodule

// ----- hdl/sgcu_banks.sv -----
// two cell bank memories, current bank flag and post-reset clearing of bank a
// depends on sgcu_pkg and sir_grid_cell_update_defines.svh
`include "sir_grid_cell_update_defines.svh"
module sgcu_banks import sgcu_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_bank_ctl                        i_ctl,
    input  logic [2*$clog2(GRID_SIDE)-1:0]   i_addr,
    input  logic [CODE_W-1:0]                i_wr_data,
    output logic [CODE_W-1:0]                o_rd_data,
    output logic                             o_clearing
);
    localparam int AW    = $clog2(GRID_SIDE);
    localparam int CAW   = 2 * AW;
    localparam int DEPTH = 1 << CAW;

    logic [CODE_W-1:0] mem_a [DEPTH];
    logic [CODE_W-1:0] mem_b [DEPTH];

    logic              r_cur_is_b;
    logic              r_clr_active;
    logic [CAW-1:0]    r_clr_addr;
    logic [CODE_W-1:0] r_rd_a;
    logic [CODE_W-1:0] r_rd_b;

    logic              w_wr_to_b;
    logic              w_we_a;
    logic              w_we_b;
    logic [CAW-1:0]    w_waddr_a;
    logic [CODE_W-1:0] w_wdata_a;

    assign w_wr_to_b = r_cur_is_b ^ i_ctl.wr_next;
    assign w_we_a    = r_clr_active || (i_ctl.wr_en && !w_wr_to_b);
    assign w_we_b    = !r_clr_active && i_ctl.wr_en && w_wr_to_b;
    assign w_waddr_a = r_clr_active ? r_clr_addr : i_addr;
    assign w_wdata_a = r_clr_active ? CODE_SUS : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            mem_a[w_waddr_a] <= w_wdata_a;
        end
        if (i_ctl.rd_en && !r_cur_is_b) begin
            r_rd_a <= mem_a[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            mem_b[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en && r_cur_is_b) begin
            r_rd_b <= mem_b[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_is_b   <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + CAW'(1);
                if (r_clr_addr == {CAW{1'b1}}) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (i_ctl.swap) begin
                r_cur_is_b <= !r_cur_is_b;
            end
        end
    end

    assign o_rd_data  = r_cur_is_b ? r_rd_b : r_rd_a;
    assign o_clearing = r_clr_active;

    `SGCU_ASSERT(a_idle_while_clearing, r_clr_active, !i_ctl.wr_en && !i_ctl.rd_en && !i_ctl.swap)
    `SGCU_ASSERT_NEXT(a_swap_toggles_bank, i_ctl.swap, r_cur_is_b != $past(r_cur_is_b))

endmodule

// ----- hdl/sgcu_seq.sv -----
// request sequencer: read-modify-write of one cell, neighbour walk, survival product
// depends on sgcu_pkg and sir_grid_cell_update_defines.svh
`include "sir_grid_cell_update_defines.svh"
module sgcu_seq import sgcu_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int PROB_BITS = PROB_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  t_req                           i_req_type,
    input  logic [COORD_W-1:0]             i_row,
    input  logic [COORD_W-1:0]             i_col,
    input  logic [CODE_W-1:0]              i_cell_value,
    input  logic [PROB_W-1:0]              i_rand_value,
    input  logic [PROB_W-1:0]              i_infect_prob,
    input  logic [PROB_W-1:0]              i_recover_prob,
    input  logic [$clog2(GRID_SIDE)-1:0]   i_row_w,
    input  logic [$clog2(GRID_SIDE)-1:0]   i_col_w,
    input  logic                           i_out_free,
    input  logic [CODE_W-1:0]              i_rd_data,
    output logic [COORD_W-1:0]             o_row_raw,
    output logic [COORD_W-1:0]             o_col_raw,
    output t_bank_ctl                      o_ctl,
    output logic [2*$clog2(GRID_SIDE)-1:0] o_addr,
    output logic [CODE_W-1:0]              o_wr_data,
    output t_seq_stat                      o_stat,
    output logic [CODE_W-1:0]              o_res_state,
    output logic [NBR_W-1:0]               o_res_nb
);
    localparam int AW  = $clog2(GRID_SIDE);
    localparam int CAW = 2 * AW;
    localparam int PW1 = PROB_BITS + 1;
    localparam int MW  = 2 * PW1;
    localparam int XW  = (PW1 > PROB_W) ? PW1 : PROB_W;
    localparam logic [PW1-1:0] ONE  = {1'b1, {PROB_BITS{1'b0}}};
    localparam logic [MW-1:0]  HALF = {{(MW-1){1'b0}}, 1'b1} << (PROB_BITS - 1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_WRAP1    = 9'b000000010,
        S_WRAP2    = 9'b000000100,
        S_OWN      = 9'b000001000,
        S_OWN_DATA = 9'b000010000,
        S_NBR      = 9'b000100000,
        S_NBR_LAST = 9'b001000000,
        S_FINAL    = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_seq_state;

    t_seq_state r_state, n_state;
    t_req                 r_req, n_req;
    logic [COORD_W-1:0]   r_row, n_row;
    logic [COORD_W-1:0]   r_col, n_col;
    logic [CODE_W-1:0]    r_val, n_val;
    logic [PROB_W-1:0]    r_rnd, n_rnd;
    logic [PW1-1:0]       r_q, n_q;
    logic [PW1-1:0]       r_s, n_s;
    logic [NBR_W-1:0]     r_cnt, n_cnt;
    logic [NBR_IDX_W-1:0] r_j, n_j;
    logic [CODE_W-1:0]    r_res_state, n_res_state;
    logic [NBR_W-1:0]     r_res_nb, n_res_nb;

    logic [XW-1:0]     w_beta_x;
    logic [XW-1:0]     w_one_x;
    logic [XW-1:0]     w_q_x;
    logic [MW-1:0]     w_prod;
    logic [PW1-1:0]    w_s_round;
    logic [PW1-1:0]    w_prob;
    logic              w_infect;
    logic              w_recover;
    logic [CODE_W-1:0] w_load_val;
    logic [AW-1:0]     w_row_m1, w_row_p1, w_col_m1, w_col_p1;
    logic [AW-1:0]     w_nbr_row, w_nbr_col;
    logic [CODE_W-1:0] w_wr_data;

    function automatic logic [AW-1:0] pick(input logic [1:0] off, input logic [AW-1:0] m1,
                                           input logic [AW-1:0] z, input logic [AW-1:0] p1);
        logic [AW-1:0] v;
        unique case (off)
            OFF_M1:  v = m1;
            OFF_P1:  v = p1;
            default: v = z;
        endcase
        return v;
    endfunction

    // complement of the saturated per-neighbour probability
    assign w_beta_x = XW'(i_infect_prob);
    assign w_one_x  = XW'(ONE);
    assign w_q_x    = w_one_x - ((w_beta_x > w_one_x) ? w_one_x : w_beta_x);

    // one rounded survival step per infected neighbour
    assign w_prod    = MW'(r_s) * MW'(r_q) + HALF;
    assign w_s_round = w_prod[PROB_BITS +: PW1];

    assign w_prob     = ONE - r_s;
    assign w_infect   = XW'(r_rnd) < XW'(w_prob);
    assign w_recover  = r_rnd < i_recover_prob;
    assign w_load_val = (r_val > CODE_REC) ? CODE_REC : r_val;

    // torus neighbours
    assign w_row_m1  = (i_row_w == '0) ? AW'(GRID_SIDE - 1) : (i_row_w - AW'(1));
    assign w_row_p1  = (i_row_w == AW'(GRID_SIDE - 1)) ? '0 : (i_row_w + AW'(1));
    assign w_col_m1  = (i_col_w == '0) ? AW'(GRID_SIDE - 1) : (i_col_w - AW'(1));
    assign w_col_p1  = (i_col_w == AW'(GRID_SIDE - 1)) ? '0 : (i_col_w + AW'(1));
    assign w_nbr_row = pick(NBR_DR[r_j], w_row_m1, i_row_w, w_row_p1);
    assign w_nbr_col = pick(NBR_DC[r_j], w_col_m1, i_col_w, w_col_p1);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_row       = r_row;
        n_col       = r_col;
        n_val       = r_val;
        n_rnd       = r_rnd;
        n_q         = r_q;
        n_s         = r_s;
        n_cnt       = r_cnt;
        n_j         = r_j;
        n_res_state = r_res_state;
        n_res_nb    = r_res_nb;
        o_ctl       = '0;
        w_wr_data   = w_load_val;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req_type;
                    n_row   = i_row;
                    n_col   = i_col;
                    n_val   = i_cell_value;
                    n_rnd   = i_rand_value;
                    n_q     = w_q_x[PW1-1:0];
                    n_state = S_WRAP1;
                end
            end
            S_WRAP1: n_state = S_WRAP2;
            S_WRAP2: n_state = S_OWN;
            S_OWN: begin
                unique case (r_req) inside
                    REQ_LOAD:             o_ctl.wr_en = 1'b1;
                    REQ_SWAP:             o_ctl.swap  = 1'b1;
                    REQ_UPDATE, REQ_READ: o_ctl.rd_en = 1'b1;
                    default:              o_ctl       = '0;
                endcase
                n_state = S_OWN_DATA;
            end
            S_OWN_DATA: begin
                n_res_nb = '0;
                n_state  = S_DONE;
                unique case (r_req) inside
                    REQ_LOAD: n_res_state = w_load_val;
                    REQ_SWAP: n_res_state = CODE_SUS;
                    REQ_READ: n_res_state = i_rd_data;
                    default: begin
                        if (i_rd_data == CODE_SUS) begin
                            n_s     = ONE;
                            n_cnt   = '0;
                            n_j     = '0;
                            n_state = S_NBR;
                        end else begin
                            if (i_rd_data == CODE_INF) begin
                                w_wr_data = w_recover ? CODE_REC : CODE_INF;
                            end else begin
                                w_wr_data = CODE_REC;
                            end
                            o_ctl.wr_en   = 1'b1;
                            o_ctl.wr_next = 1'b1;
                            n_res_state   = w_wr_data;
                        end
                    end
                endcase
            end
            S_NBR: begin
                o_ctl.rd_en = 1'b1;
                n_j         = r_j + NBR_IDX_W'(1);
                // data of the previous neighbour arrives while the next is issued
                if (r_j != '0 && i_rd_data == CODE_INF) begin
                    n_cnt = r_cnt + NBR_W'(1);
                    n_s   = w_s_round;
                end
                if (r_j == NBR_IDX_W'(NBR_NUM - 1)) begin
                    n_state = S_NBR_LAST;
                end
            end
            S_NBR_LAST: begin
                if (i_rd_data == CODE_INF) begin
                    n_cnt = r_cnt + NBR_W'(1);
                    n_s   = w_s_round;
                end
                n_state = S_FINAL;
            end
            S_FINAL: begin
                w_wr_data     = w_infect ? CODE_INF : CODE_SUS;
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_next = 1'b1;
                n_res_state   = w_wr_data;
                n_res_nb      = r_cnt;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_row       <= n_row;
        r_col       <= n_col;
        r_val       <= n_val;
        r_rnd       <= n_rnd;
        r_q         <= n_q;
        r_s         <= n_s;
        r_cnt       <= n_cnt;
        r_j         <= n_j;
        r_res_state <= n_res_state;
        r_res_nb    <= n_res_nb;
    end

    assign o_row_raw        = r_row;
    assign o_col_raw        = r_col;
    assign o_addr           = (r_state == S_NBR) ? {w_nbr_row, w_nbr_col} : {i_row_w, i_col_w};
    assign o_wr_data        = w_wr_data;
    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_res_state      = r_res_state;
    assign o_res_nb         = r_res_nb;

    `SGCU_ASSERT_NEXT(a_start_from_idle, i_start, r_state == S_WRAP1)
    `SGCU_ASSERT(a_no_hits_full_survival, (r_state == S_FINAL) && (r_cnt == '0), r_s == ONE)
    `SGCU_ASSERT(a_count_in_range, r_state == S_FINAL, r_cnt <= NBR_W'(NBR_NUM))

endmodule

// ----- hdl/sir_grid_cell_update.sv -----
// top level of the sir grid cell update block: config registers, handshakes, result register
// depends on sgcu_pkg, sgcu_wrap, sgcu_banks and sgcu_seq
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  -------------------------------------
//  request   in         i_in_valid / o_in_stall      req_type, row, col, cell_value, rand_value
//  result    out        o_out_valid / i_out_stall    cell_state, infected_neighbours
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one request is worked at a time; load, read, swap and the update of a non-susceptible
// cell go through the wrap states, the own-cell access and its data state to a loaded
// result register; the update of a susceptible cell adds the eight neighbour reads through
// the one read port of the current bank. after reset bank a is cleared one cell per cycle,
// all 4^ceil(log2(side)) cells (262144 at side 512), during which requests are stalled
// (config writes still go). a result waiting under i_out_stall holds the sequencer in its
// last state, but the next request is accepted once the sequencer has handed its result over.
module sir_grid_cell_update import sgcu_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int PROB_BITS = PROB_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [COORD_W-1:0]    i_row,
    input  logic [COORD_W-1:0]    i_col,
    input  logic [CODE_W-1:0]     i_cell_value,
    input  logic [PROB_W-1:0]     i_rand_value,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CODE_W-1:0]     o_cell_state,
    output logic [NBR_W-1:0]      o_infected_neighbours,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);
    localparam int AW  = $clog2(GRID_SIDE);
    localparam int CAW = 2 * AW;

    // configuration registers
    logic [PROB_W-1:0] r_infect_prob;
    logic [PROB_W-1:0] r_recover_prob;
    logic              w_cfg_wr;

    // request side
    logic              w_in_accept;
    logic              w_clearing;
    t_seq_stat         w_seq_stat;

    // sequencer, wrap units and banks
    logic [COORD_W-1:0] w_row_raw;
    logic [COORD_W-1:0] w_col_raw;
    logic [AW-1:0]      w_row_w;
    logic [AW-1:0]      w_col_w;
    t_bank_ctl          w_bank_ctl;
    logic [CAW-1:0]     w_bank_addr;
    logic [CODE_W-1:0]  w_bank_wr_data;
    logic [CODE_W-1:0]  w_bank_rd_data;
    logic [CODE_W-1:0]  w_res_state;
    logic [NBR_W-1:0]   w_res_nb;

    // result register
    logic              w_out_free;
    logic              w_out_load;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_state;
    logic [NBR_W-1:0]  r_out_nb;

    // apb: zero wait states, register index from the word address
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infect_prob  <= RST_INFECT;
            r_recover_prob <= RST_RECOVER;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_INFECT:  r_infect_prob  <= pwdata[PROB_W-1:0];
                REG_RECOVER: r_recover_prob <= pwdata[PROB_W-1:0];
                default:     r_infect_prob  <= r_infect_prob;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INFECT:  prdata = DATA_W'(r_infect_prob);
            REG_RECOVER: prdata = DATA_W'(r_recover_prob);
            default:     prdata = '0;
        endcase
    end

    // a transaction is taken only while the sequencer is free and the clear is over
    assign o_in_stall  = w_seq_stat.busy || w_clearing;
    assign w_in_accept = i_in_valid && !o_in_stall;

    sgcu_seq #(
        .GRID_SIDE (GRID_SIDE),
        .PROB_BITS (PROB_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_in_accept),
        .i_req_type     (t_req'(i_req_type)),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_cell_value   (i_cell_value),
        .i_rand_value   (i_rand_value),
        .i_infect_prob  (r_infect_prob),
        .i_recover_prob (r_recover_prob),
        .i_row_w        (w_row_w),
        .i_col_w        (w_col_w),
        .i_out_free     (w_out_free),
        .i_rd_data      (w_bank_rd_data),
        .o_row_raw      (w_row_raw),
        .o_col_raw      (w_col_raw),
        .o_ctl          (w_bank_ctl),
        .o_addr         (w_bank_addr),
        .o_wr_data      (w_bank_wr_data),
        .o_stat         (w_seq_stat),
        .o_res_state    (w_res_state),
        .o_res_nb       (w_res_nb)
    );

    // row and column reduced onto the torus before any bank access
    sgcu_wrap #(
        .GRID_SIDE (GRID_SIDE)
    ) u_wrap_row (
        .i_clk (i_clk),
        .i_x   (w_row_raw),
        .o_y   (w_row_w)
    );

    sgcu_wrap #(
        .GRID_SIDE (GRID_SIDE)
    ) u_wrap_col (
        .i_clk (i_clk),
        .i_x   (w_col_raw),
        .o_y   (w_col_w)
    );

    sgcu_banks #(
        .GRID_SIDE (GRID_SIDE)
    ) u_banks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_bank_ctl),
        .i_addr     (w_bank_addr),
        .i_wr_data  (w_bank_wr_data),
        .o_rd_data  (w_bank_rd_data),
        .o_clearing (w_clearing)
    );

    // result register: refilled when empty or when its transaction leaves this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = w_seq_stat.res_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_state <= w_res_state;
            r_out_nb    <= w_res_nb;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_cell_state          = r_out_state;
    assign o_infected_neighbours = r_out_nb;

endmodule
